/* hdl/timestamped_event_log_player_defines.svh */
// Assertion macros for the event log player checker.
// No dependencies; included by files that assert.
`ifndef TIMESTAMPED_EVENT_LOG_PLAYER_DEFINES_SVH
`define TIMESTAMPED_EVENT_LOG_PLAYER_DEFINES_SVH

// same-cycle implication
`define TEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event log player check failed");

// next-cycle implication
`define TEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event log player check failed");

`endif

/* hdl/tel_pkg.sv */
// Shared constants, types and opcodes for the event log player.
// No dependencies.
package tel_pkg;

    localparam int LOG_DEPTH = 4096;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    localparam int FRAME_W   = 32;
    localparam int SLOT_W    = 2;
    localparam int BTN_W     = 16;
    localparam int TRIG_W    = 8;
    localparam int PAY_W     = SLOT_W + BTN_W + 2 * TRIG_W;
    localparam int OP_W      = 3;
    localparam int IN_RAW_W  = FRAME_W + SLOT_W + BTN_W + 2 * TRIG_W;
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = BTN_W + 2 * TRIG_W;

    localparam logic [CNT_W-1:0] FULL_COUNT   = CNT_W'(LOG_DEPTH);
    localparam logic [BTN_W-1:0] IDLE_BUTTONS = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_START  = 3'd1,
        OP_QUERY  = 3'd2,
        OP_SEEK   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_QCMP,
        S_QEND,
        S_SCMP,
        S_HOLD
    } t_state;

endpackage

/* hdl/timestamped_event_log_player.sv */
// Event log player top level: log memories, cursors, sticky values, control.
// Depends on tel_pkg and tel_ram.
//
//  channel   | dir | handshake                        | payload
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tuser opcode, tdata entry/query fields
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tuser ok, tdata held values
//
// Append, start, clear and unused codes finish in S_EXEC.
// Query: S_EXEC, then S_QCMP for each log entry compared, then S_QEND; seek: S_EXEC, then
// S_SCMP for each entry compared (an empty log ends in S_EXEC): the log memories have one read port.
// Reset clears control, count, cursors and sticky values; the log memories are not swept.
// One result register: a new request is taken while a result waits; a finished request
// waits in a holding register until the result register frees.
module timestamped_event_log_player (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // frame_number, player_slot, button_bits, left_trigger, right_trigger, zero pad
    input  logic [tel_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic [tel_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // held_buttons, held_left_trigger, held_right_trigger
    output logic [tel_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // ok
    output logic [0:0]                     o_m_axis_tuser
);

    localparam int FW = tel_pkg::FRAME_W;
    localparam int SW = tel_pkg::SLOT_W;
    localparam int BW = tel_pkg::BTN_W;
    localparam int TW = tel_pkg::TRIG_W;
    localparam int CW = tel_pkg::CNT_W;
    localparam int IW = tel_pkg::IDX_W;
    localparam int PW = tel_pkg::PAY_W;
    localparam int OW = tel_pkg::OUT_DATA_W;

    tel_pkg::t_state r_state, n_state;
    tel_pkg::t_op    r_op;

    logic [FW-1:0] r_frame;
    logic [SW-1:0] r_slot;
    logic [BW-1:0] r_btn;
    logic [TW-1:0] r_lt;
    logic [TW-1:0] r_rt;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_cur;
    logic [CW-1:0] r_cursor [2];
    logic [BW-1:0] r_stk_btn [2];
    logic [TW-1:0] r_stk_lt [2];
    logic [TW-1:0] r_stk_rt [2];
    logic          r_playing;
    logic          r_seen;

    logic          r_res_ok;
    logic [OW-1:0] r_res_data;
    logic          r_out_valid;
    logic          r_out_ok;
    logic [OW-1:0] r_out_data;

    logic          wr_en;
    logic [IW-1:0] rd_addr;
    logic [FW-1:0] frame_rdata;
    logic [PW-1:0] pay_rdata;
    logic          fin;
    logic          fin_ok;
    logic [OW-1:0] fin_data;
    logic          out_free;
    logic          sel;
    logic          q_go;
    logic          hit_q;
    logic          hit_s;
    logic          more;
    logic [CW-1:0] cur_inc;

    assign sel      = r_slot[0];
    assign q_go     = !r_slot[1] && r_playing;
    assign cur_inc  = r_cur + CW'(1);
    assign more     = cur_inc < r_count;
    assign hit_q    = frame_rdata <= r_frame;
    assign hit_s    = frame_rdata >= r_frame;
    assign out_free = !r_out_valid || i_m_axis_tready;

    tel_ram #(.W(FW), .D(tel_pkg::LOG_DEPTH)) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (r_frame),
        .i_rd_addr (rd_addr),
        .o_rd_data (frame_rdata)
    );

    tel_ram #(.W(PW), .D(tel_pkg::LOG_DEPTH)) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data ({r_slot, r_btn, r_lt, r_rt}),
        .i_rd_addr (rd_addr),
        .o_rd_data (pay_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tel_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = tel_pkg::S_EXEC;
                end
            end
            tel_pkg::S_EXEC: begin
                if (r_op == tel_pkg::OP_QUERY && q_go) begin
                    n_state = (r_cursor[sel] < r_count) ? tel_pkg::S_QCMP : tel_pkg::S_QEND;
                end else if (r_op == tel_pkg::OP_SEEK && r_count != '0) begin
                    n_state = tel_pkg::S_SCMP;
                end
            end
            tel_pkg::S_QCMP: begin
                if (!(hit_q && more)) begin
                    n_state = tel_pkg::S_QEND;
                end
            end
            tel_pkg::S_HOLD: begin
                if (out_free) begin
                    n_state = tel_pkg::S_IDLE;
                end
            end
            default: n_state = r_state;
        endcase
        if (fin) begin
            n_state = out_free ? tel_pkg::S_IDLE : tel_pkg::S_HOLD;
        end
    end

    // outputs of each state
    always_comb begin
        wr_en    = 1'b0;
        rd_addr  = r_cur[IW-1:0];
        fin      = 1'b0;
        fin_ok   = 1'b0;
        fin_data = '0;
        case (r_state)
            tel_pkg::S_EXEC: begin
                case (r_op)
                    tel_pkg::OP_APPEND: begin
                        fin    = 1'b1;
                        fin_ok = r_count != tel_pkg::FULL_COUNT;
                        wr_en  = r_count != tel_pkg::FULL_COUNT;
                    end
                    tel_pkg::OP_START: begin
                        fin    = 1'b1;
                        fin_ok = !r_playing;
                    end
                    tel_pkg::OP_QUERY: begin
                        rd_addr = r_cursor[sel][IW-1:0];
                        fin     = !q_go;
                    end
                    tel_pkg::OP_SEEK: begin
                        rd_addr = '0;
                        fin     = r_count == '0;
                        fin_ok  = 1'b1;
                    end
                    tel_pkg::OP_CLEAR: begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                    default: fin = 1'b1;
                endcase
            end
            tel_pkg::S_QCMP: begin
                rd_addr = cur_inc[IW-1:0];
            end
            tel_pkg::S_QEND: begin
                fin      = 1'b1;
                fin_ok   = r_seen || r_cur != '0;
                fin_data = {r_stk_rt[sel], r_stk_lt[sel], r_stk_btn[sel]};
            end
            tel_pkg::S_SCMP: begin
                rd_addr = cur_inc[IW-1:0];
                fin     = hit_s || !more;
                fin_ok  = 1'b1;
            end
            default: rd_addr = r_cur[IW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tel_pkg::S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_playing   <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_cursor[s]  <= '0;
                r_stk_btn[s] <= tel_pkg::IDLE_BUTTONS;
                r_stk_lt[s]  <= '0;
                r_stk_rt[s]  <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                tel_pkg::S_EXEC: begin
                    case (r_op)
                        tel_pkg::OP_APPEND: begin
                            if (r_count != tel_pkg::FULL_COUNT) begin
                                r_count <= r_count + CW'(1);
                            end
                        end
                        tel_pkg::OP_START: begin
                            if (!r_playing) begin
                                r_playing <= 1'b1;
                                for (int s = 0; s < 2; s++) begin
                                    r_cursor[s]  <= '0;
                                    r_stk_btn[s] <= tel_pkg::IDLE_BUTTONS;
                                    r_stk_lt[s]  <= '0;
                                    r_stk_rt[s]  <= '0;
                                end
                            end
                        end
                        tel_pkg::OP_QUERY: begin
                            r_cur  <= r_cursor[sel];
                            r_seen <= 1'b0;
                        end
                        tel_pkg::OP_SEEK: begin
                            r_cur <= '0;
                            for (int s = 0; s < 2; s++) begin
                                r_stk_btn[s] <= tel_pkg::IDLE_BUTTONS;
                                r_stk_lt[s]  <= '0;
                                r_stk_rt[s]  <= '0;
                                if (r_count == '0) begin
                                    r_cursor[s] <= '0;
                                end
                            end
                        end
                        tel_pkg::OP_CLEAR: begin
                            r_playing <= 1'b0;
                            r_count   <= '0;
                            for (int s = 0; s < 2; s++) begin
                                r_cursor[s] <= '0;
                            end
                        end
                        default: r_cur <= r_cur;
                    endcase
                end
                tel_pkg::S_QCMP: begin
                    if (hit_q) begin
                        r_cur <= cur_inc;
                        if (pay_rdata[PW-1 -: SW] == r_slot) begin
                            r_stk_btn[sel] <= pay_rdata[2*TW +: BW];
                            r_stk_lt[sel]  <= pay_rdata[TW +: TW];
                            r_stk_rt[sel]  <= pay_rdata[0 +: TW];
                            r_seen         <= 1'b1;
                        end
                    end
                end
                tel_pkg::S_QEND: begin
                    r_cursor[sel] <= r_cur;
                end
                tel_pkg::S_SCMP: begin
                    if (hit_s) begin
                        r_cursor[0] <= r_cur;
                        r_cursor[1] <= r_cur;
                    end else if (more) begin
                        r_cur <= cur_inc;
                    end else begin
                        r_cursor[0] <= '0;
                        r_cursor[1] <= '0;
                    end
                end
                default: r_cur <= r_cur;
            endcase
            if (fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == tel_pkg::S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == tel_pkg::S_IDLE && i_s_axis_tvalid) begin
            r_op    <= tel_pkg::t_op'(i_s_axis_tuser);
            r_frame <= i_s_axis_tdata[0 +: FW];
            r_slot  <= i_s_axis_tdata[FW +: SW];
            r_btn   <= i_s_axis_tdata[FW+SW +: BW];
            r_lt    <= i_s_axis_tdata[FW+SW+BW +: TW];
            r_rt    <= i_s_axis_tdata[FW+SW+BW+TW +: TW];
        end
        if (fin && !out_free) begin
            r_res_ok   <= fin_ok;
            r_res_data <= fin_data;
        end
        if (fin && out_free) begin
            r_out_ok   <= fin_ok;
            r_out_data <= fin_data;
        end else if (r_state == tel_pkg::S_HOLD && out_free) begin
            r_out_ok   <= r_res_ok;
            r_out_data <= r_res_data;
        end
    end

    assign o_s_axis_tready = r_state == tel_pkg::S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ok;

endmodule

/* hdl/tel_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tel_ram #(
    parameter int W = 32,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [$clog2(D)-1:0] i_wr_addr,
    input  logic [W-1:0]         i_wr_data,
    input  logic [$clog2(D)-1:0] i_rd_addr,
    output logic [W-1:0]         o_rd_data
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* hdl/tel_checker.sv */
// Port-level checker for the event log player, bound to the top level.
// Depends on tel_pkg and timestamped_event_log_player_defines.svh.
`include "timestamped_event_log_player_defines.svh"

module tel_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tel_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                     o_m_axis_tuser
);

    logic in_req;
    logic out_stall;

    assign in_req    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `TEL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    `TEL_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_req, !o_s_axis_tready)

    `TEL_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_m_axis_tvalid),
        $past(!o_s_axis_tready))

    `TEL_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready)

endmodule

bind timestamped_event_log_player tel_checker u_tel_checker (.*);
